// File: hdl/hslwm_pkg.sv
// Package with the widths, constants and types that the block's files share.
package hslwm_pkg;

  localparam int PIX_W = 16;
  localparam int CMP_W = 8;
  localparam int SUM_W = 9;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;
  localparam int HNUM_W = 14;
  localparam int SNUM_W = 16;
  localparam int DIV_STAGES = 4;
  localparam int PIPE_STAGES = 6;

  localparam logic [CMP_W-1:0] HUE_BASE_RED = 8'd0;
  localparam logic [CMP_W-1:0] HUE_BASE_RED_WRAP = 8'd240;
  localparam logic [CMP_W-1:0] HUE_BASE_GREEN = 8'd80;
  localparam logic [CMP_W-1:0] HUE_BASE_BLUE = 8'd160;
  localparam logic [SUM_W-1:0] SAT_SPLIT_SUM = 9'd257;
  localparam logic [SUM_W-1:0] SAT_FULL_SUM = 9'd510;
  localparam logic [SUM_W-1:0] LUM_ZERO_SUM = 9'd2;
  localparam logic [11:0] LUM_RECIP = 12'd3855;
  localparam logic [CMP_W-1:0] LUM_DIV = 8'd17;
  localparam logic [CMP_W-1:0] CMP_MAX = 8'd240;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HUE_LOW  = 3'd0,
    REG_HUE_HIGH = 3'd1,
    REG_SAT_LOW  = 3'd2,
    REG_SAT_HIGH = 3'd3,
    REG_LUM_LOW  = 3'd4,
    REG_LUM_HIGH = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [CMP_W-1:0] hue_low;
    logic [CMP_W-1:0] hue_high;
    logic [CMP_W-1:0] sat_low;
    logic [CMP_W-1:0] sat_high;
    logic [CMP_W-1:0] lum_low;
    logic [CMP_W-1:0] lum_high;
  } cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [HNUM_W-1:0] hnum;
    logic [CMP_W-1:0]  hden;
    logic [CMP_W-1:0]  hbase;
    logic              hneg;
    logic [SNUM_W-1:0] snum;
    logic [SUM_W-1:0]  sden;
  } prep_t;

endpackage

// File: hdl/hslwm_if.sv
// Interfaces for the pixel, result and configuration channels.
interface hslwm_pix_if;
  import hslwm_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  modport source(output valid, output pixel, input ready);
  modport sink(input valid, input pixel, output ready);
endinterface

interface hslwm_res_if;
  import hslwm_pkg::*;
  logic             valid;
  logic             ready;
  logic [CMP_W-1:0] hue;
  logic [CMP_W-1:0] saturation;
  logic [CMP_W-1:0] luminance;
  logic             in_window;
  modport source(output valid, output hue, output saturation, output luminance,
                 output in_window, input ready);
  modport sink(input valid, input hue, input saturation, input luminance,
               input in_window, output ready);
endinterface

interface hslwm_cfg_if;
  import hslwm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// File: hdl/hslwm_cfg_regs.sv
// Window bound registers written through the configuration channel.
module hslwm_cfg_regs (
  input  logic            clk,
  input  logic            rst,
  hslwm_cfg_if.sink       cfg,
  output hslwm_pkg::cfg_t regs
);
  import hslwm_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.hue_low  <= '0;
      regs.hue_high <= CMP_MAX;
      regs.sat_low  <= '0;
      regs.sat_high <= CMP_MAX;
      regs.lum_low  <= '0;
      regs.lum_high <= CMP_MAX;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_HUE_LOW:  regs.hue_low  <= cfg.data;
        REG_HUE_HIGH: regs.hue_high <= cfg.data;
        REG_SAT_LOW:  regs.sat_low  <= cfg.data;
        REG_SAT_HIGH: regs.sat_high <= cfg.data;
        REG_LUM_LOW:  regs.lum_low  <= cfg.data;
        REG_LUM_HIGH: regs.lum_high <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/hslwm_prep.sv
// First stage: unpacks the pixel, finds max and min, and sets up both divisions.
module hslwm_prep (
  input  logic                         clk,
  input  logic                         en,
  input  logic [hslwm_pkg::PIX_W-1:0]  pixel,
  output hslwm_pkg::prep_t             prep
);
  import hslwm_pkg::*;

  logic [CMP_W-1:0] r, g, b, mx, mn, dif, d;
  logic [SUM_W-1:0] sum;
  prep_t            prep_next;

  always_comb begin
    r = {pixel[15:11], 3'b000};
    g = {pixel[10:5], 2'b00};
    b = {pixel[4:0], 3'b000};
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    sum = SUM_W'(mx) + SUM_W'(mn);
    dif = mx - mn;

    if (mx == r) begin
      if (g >= b) begin
        d = g - b;
        prep_next.hbase = HUE_BASE_RED;
        prep_next.hneg = 1'b0;
      end else begin
        d = b - g;
        prep_next.hbase = HUE_BASE_RED_WRAP;
        prep_next.hneg = 1'b1;
      end
    end else if (mx == g) begin
      d = (b >= r) ? b - r : r - b;
      prep_next.hbase = HUE_BASE_GREEN;
      prep_next.hneg = (b < r);
    end else begin
      d = (r >= g) ? r - g : g - r;
      prep_next.hbase = HUE_BASE_BLUE;
      prep_next.hneg = (r < g);
    end

    prep_next.sum = sum;
    prep_next.hnum = (HNUM_W'(d) << 5) + (HNUM_W'(d) << 3);
    prep_next.hden = dif;
    prep_next.snum = (SNUM_W'(dif) << 8) - (SNUM_W'(dif) << 4);
    prep_next.sden = (sum <= SAT_SPLIT_SUM) ? sum : SAT_FULL_SUM - sum;

    // A grey pixel divides 0 by 1 in both divisions; one so dark that luminance is zero does so for saturation.
    if (dif == '0) begin
      prep_next.hnum = '0;
      prep_next.hden = CMP_W'(1);
      prep_next.hbase = HUE_BASE_RED;
      prep_next.hneg = 1'b0;
    end
    if (dif == '0 || sum <= LUM_ZERO_SUM) begin
      prep_next.snum = '0;
      prep_next.sden = SUM_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep <= prep_next;
    end
  end

endmodule

// File: hdl/hslwm_div.sv
// Pipelined restoring divider that resolves a fixed number of quotient bits per stage.
module hslwm_div #(
  parameter int NUM_W = 16,
  parameter int DEN_W = 9,
  parameter int QUO_W = 8,
  parameter int STAGES = 4
) (
  input  logic              clk,
  input  logic [STAGES-1:0] en,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  output logic [QUO_W-1:0]  quo
);
  localparam int BPS = (QUO_W + STAGES - 1) / STAGES;
  localparam int CW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic [NUM_W-1:0] rem_p [STAGES+1];
  logic [DEN_W-1:0] den_p [STAGES+1];
  logic [QUO_W-1:0] quo_p [STAGES+1];

  assign rem_p[0] = num;
  assign den_p[0] = den;
  assign quo_p[0] = '0;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [CW-1:0]    rem_next;
    logic [QUO_W-1:0] quo_next;

    always_comb begin
      logic [CW-1:0] trial;
      int            sh;
      rem_next = CW'(rem_p[s]);
      quo_next = quo_p[s];
      for (int j = 0; j < BPS; j++) begin
        sh = QUO_W - 1 - (s * BPS + j);
        if (sh >= 0) begin
          trial = CW'(den_p[s]) << sh;
          if (rem_next >= trial) begin
            rem_next = rem_next - trial;
            quo_next = {quo_next[QUO_W-2:0], 1'b1};
          end else begin
            quo_next = {quo_next[QUO_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        rem_p[s+1] <= rem_next[NUM_W-1:0];
        den_p[s+1] <= den_p[s];
        quo_p[s+1] <= quo_next;
      end
    end
  end

  assign quo = quo_p[STAGES];

endmodule

// File: hdl/hslwm_lum.sv
// Luminance as floor(sum * 8 / 17) by a reciprocal multiply and one correction step.
module hslwm_lum (
  input  logic                               clk,
  input  logic [1:0]                         en,
  input  logic [hslwm_pkg::SUM_W-1:0]        sum,
  output logic [hslwm_pkg::CMP_W-1:0]        lum
);
  import hslwm_pkg::*;

  logic [11:0]      x, x_q;
  logic [23:0]      prod;
  logic [CMP_W-1:0] est_q;
  logic [12:0]      rem;

  assign x = {sum, 3'b000};
  assign prod = 24'(x) * 24'(LUM_RECIP);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x_q <= x;
      est_q <= prod[23:16];
    end
  end

  assign rem = 13'(x_q) - 13'(est_q) * 13'(LUM_DIV);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      lum <= (rem >= 13'(LUM_DIV)) ? est_q + CMP_W'(1) : est_q;
    end
  end

endmodule

// File: hdl/rgb565_to_hsl_window_match_core.sv
// Top level: RGB565 to HSL (0..240 scale) converter with a window match flag.
//
//   channel  dir  payload                                       handshake
//   pix      in   pixel[15:0]                                   valid/ready
//   res      out  hue[7:0] saturation[7:0] luminance[7:0] in_window  valid/ready
//   cfg      in   index[2:0] data[7:0]                          valid/ready
//
// Six register stages: setup, four divider stages at two quotient bits each, and the
// output register. One pixel per cycle is sustained while the result side is ready.
// Each stage holds while its successor is full and stalled, so bubbles close up.
// Reset clears the stage valid bits and loads the window registers with 0 and 240.
// Configuration writes are always ready.
module rgb565_to_hsl_window_match_core (
  input logic        clk,
  input logic        rst,
  hslwm_pix_if.sink  pix,
  hslwm_res_if.source res,
  hslwm_cfg_if.sink  cfg
);
  import hslwm_pkg::*;

  cfg_t                   regs;
  prep_t                  prep;
  logic [PIPE_STAGES-1:0] vld;
  logic [PIPE_STAGES-1:0] en;
  logic [CMP_W-1:0]       hbase_d [1:DIV_STAGES];
  logic                   hneg_d [1:DIV_STAGES];
  logic [CMP_W-1:0]       lum_s2, lum_d3, lum_d4;
  logic [CMP_W-1:0]       hq, sq, h;
  logic                   win;

  hslwm_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  always_comb begin
    en[PIPE_STAGES-1] = !vld[PIPE_STAGES-1] || res.ready;
    for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign pix.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= pix.valid;
      for (int k = 1; k < PIPE_STAGES; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  hslwm_prep u_prep (
    .clk   (clk),
    .en    (en[0]),
    .pixel (pix.pixel),
    .prep  (prep)
  );

  hslwm_div #(
    .NUM_W  (HNUM_W),
    .DEN_W  (CMP_W),
    .QUO_W  (CMP_W),
    .STAGES (DIV_STAGES)
  ) u_hue_div (
    .clk (clk),
    .en  (en[DIV_STAGES:1]),
    .num (prep.hnum),
    .den (prep.hden),
    .quo (hq)
  );

  hslwm_div #(
    .NUM_W  (SNUM_W),
    .DEN_W  (SUM_W),
    .QUO_W  (CMP_W),
    .STAGES (DIV_STAGES)
  ) u_sat_div (
    .clk (clk),
    .en  (en[DIV_STAGES:1]),
    .num (prep.snum),
    .den (prep.sden),
    .quo (sq)
  );

  hslwm_lum u_lum (
    .clk (clk),
    .en  (en[2:1]),
    .sum (prep.sum),
    .lum (lum_s2)
  );

  always_ff @(posedge clk) begin
    if (en[1]) begin
      hbase_d[1] <= prep.hbase;
      hneg_d[1] <= prep.hneg;
    end
    for (int k = 2; k <= DIV_STAGES; k++) begin
      if (en[k]) begin
        hbase_d[k] <= hbase_d[k-1];
        hneg_d[k] <= hneg_d[k-1];
      end
    end
    if (en[3]) lum_d3 <= lum_s2;
    if (en[4]) lum_d4 <= lum_d3;
  end

  assign h = hneg_d[DIV_STAGES] ? hbase_d[DIV_STAGES] - hq : hbase_d[DIV_STAGES] + hq;

  assign win = (h > regs.hue_low) && (h < regs.hue_high) &&
               (sq > regs.sat_low) && (sq < regs.sat_high) &&
               (lum_d4 > regs.lum_low) && (lum_d4 < regs.lum_high);

  always_ff @(posedge clk) begin
    if (en[PIPE_STAGES-1]) begin
      res.hue <= h;
      res.saturation <= sq;
      res.luminance <= lum_d4;
      res.in_window <= win;
    end
  end

  assign res.valid = vld[PIPE_STAGES-1];

endmodule

// File: hdl/hslwm_checker.sv
// Checker on the top level's ports, with the bind that attaches it.
module hslwm_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] hue,
  input logic [7:0] saturation,
  input logic [7:0] luminance,
  input logic       in_window
);

  a_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> hue <= 8'd240 && saturation <= 8'd240 && luminance <= 8'd235)
    else $error("result component out of range");

  a_window_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid && in_window |-> hue != 8'd0 && saturation != 8'd0 && luminance != 8'd0)
    else $error("window match with a zero component");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result beat dropped while stalled");

endmodule

bind rgb565_to_hsl_window_match_core hslwm_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .hue        (res.hue),
  .saturation (res.saturation),
  .luminance  (res.luminance),
  .in_window  (res.in_window)
);

// File: tb/tb_rgb565_to_hsl_window_match_core.sv
// Self-checking testbench for the RGB565 to HSL converter and its window match flag.
module tb_rgb565_to_hsl_window_match_core;
  timeunit 1ns;
  timeprecision 1ps;

  import hslwm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
  localparam int DIR_ROWS = 22;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 130;

  typedef struct packed {
    logic [CMP_W-1:0] hue;
    logic [CMP_W-1:0] saturation;
    logic [CMP_W-1:0] luminance;
    logic             in_window;
  } hsl_t;

  typedef struct {
    logic [PIX_W-1:0] pixel;
    bit               typed;
    hsl_t             want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hslwm_pix_if pix_ch();
  hslwm_res_if res_ch();
  hslwm_cfg_if cfg_ch();

  rgb565_to_hsl_window_match_core dut (
    .clk(clk),
    .rst(rst),
    .pix(pix_ch),
    .res(res_ch),
    .cfg(cfg_ch)
  );

  hsl_t     hsl_due[$];
  cfg_t     win;
  bit       pix_typed = 1'b0;
  hsl_t     pix_want = '0;
  bit       quiet = 1'b0;
  int       stall_left = 0;
  int       mismatches = 0;
  dir_row_t dir_rows [DIR_ROWS];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int clamp_240(int v);
    if (v > 240) return 240;
    if (v < 0) return 0;
    return v;
  endfunction

  function automatic logic [7:0] clip_u8(int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return 8'(v);
  endfunction

  function automatic hsl_t predict_hsl(logic [PIX_W-1:0] px, cfg_t w);
    int r, g, b, hi, lo, sum, dif, h, s, l;
    hsl_t o;
    r = {px[15:11], 3'b000};
    g = {px[10:5], 2'b00};
    b = {px[4:0], 3'b000};
    hi = r;
    lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    sum = hi + lo;
    dif = hi - lo;
    l = ((sum * 240) / 255) / 2;
    if (dif == 0) begin
      h = 0;
      s = 0;
    end else begin
      if (hi == r) begin
        if (g >= b) h = (40 * (g - b)) / dif;
        else h = (40 * (g - b)) / dif + 240;
      end else if (hi == g) begin
        h = (40 * (b - r)) / dif + 80;
      end else begin
        h = (40 * (r - g)) / dif + 160;
      end
      if (l == 0) s = 0;
      else if (l <= 120) s = (dif * 240) / sum;
      else s = (dif * 240) / (510 - sum);
    end
    h = clamp_240(h);
    s = clamp_240(s);
    l = clamp_240(l);
    o.hue = 8'(h);
    o.saturation = 8'(s);
    o.luminance = 8'(l);
    o.in_window = h > int'(w.hue_low) && h < int'(w.hue_high) &&
                  s > int'(w.sat_low) && s < int'(w.sat_high) &&
                  l > int'(w.lum_low) && l < int'(w.lum_high);
    return o;
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel(logic [PIX_W-1:0] anchor);
    logic [4:0] k;
    k = 5'($urandom);
    case ($urandom_range(0, 5))
      0: return {k, k, 1'($urandom), k};
      1: return anchor ^ (16'($urandom) & 16'h1863);
      2: return anchor ^ (16'($urandom) & 16'h38e7);
      3: return {5'($urandom_range(28, 31)), 6'($urandom_range(0, 8)), k};
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : scoreboard
    hsl_t want;
    if (rst) begin
      win = '{8'd0, CMP_MAX, 8'd0, CMP_MAX, 8'd0, CMP_MAX};
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (hsl_due.size() == 0) begin
          $error("result beat with no pixel pending");
          mismatches++;
        end else begin
          want = hsl_due.pop_front();
          check_field("hue", want.hue, res_ch.hue);
          check_field("saturation", want.saturation, res_ch.saturation);
          check_field("luminance", want.luminance, res_ch.luminance);
          check_field("in_window", want.in_window, res_ch.in_window);
        end
      end
      if (pix_ch.valid && pix_ch.ready) begin
        hsl_due.push_back(pix_typed ? pix_want : predict_hsl(pix_ch.pixel, win));
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_HUE_LOW:  win.hue_low = cfg_ch.data;
          REG_HUE_HIGH: win.hue_high = cfg_ch.data;
          REG_SAT_LOW:  win.sat_low = cfg_ch.data;
          REG_SAT_HIGH: win.sat_high = cfg_ch.data;
          REG_LUM_LOW:  win.lum_low = cfg_ch.data;
          REG_LUM_HIGH: win.lum_high = cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      res_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      res_ch.ready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  task automatic push_pixel(input logic [PIX_W-1:0] px, input bit typed, input hsl_t want);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      pix_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.pixel <= px;
    pix_typed <= typed;
    pix_want <= want;
    do @(posedge clk); while (!pix_ch.ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  task automatic load_windows(input cfg_t w);
    write_reg(REG_HUE_LOW, w.hue_low);
    write_reg(REG_HUE_HIGH, w.hue_high);
    write_reg(REG_SAT_LOW, w.sat_low);
    write_reg(REG_SAT_HIGH, w.sat_high);
    write_reg(REG_LUM_LOW, w.lum_low);
    write_reg(REG_LUM_HIGH, w.lum_high);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain_results();
    while (hsl_due.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin : stimulus
    logic [PIX_W-1:0] anchor;
    hsl_t             ahsl;
    cfg_t             w;
    int               d;
    pix_ch.valid = 1'b0;
    pix_ch.pixel = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    res_ch.ready = 1'b0;
    dir_rows = '{
      '{16'h0000, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b0}},
      '{16'hf800, 1'b1, '{8'd0, 8'd240, 8'd116, 1'b0}},
      '{16'h07e0, 1'b1, '{8'd80, 8'd240, 8'd118, 1'b0}},
      '{16'h001f, 1'b1, '{8'd160, 8'd240, 8'd116, 1'b0}},
      '{16'h0841, 1'b1, '{8'd0, 8'd0, 8'd7, 1'b0}},
      '{16'hffff, 1'b0, '0},
      '{16'hffdf, 1'b0, '0},
      '{16'hf821, 1'b0, '0},
      '{16'hf801, 1'b0, '0},
      '{16'hf81f, 1'b0, '0},
      '{16'hffc0, 1'b0, '0},
      '{16'h07ff, 1'b0, '0},
      '{16'hffe0, 1'b0, '0},
      '{16'h8410, 1'b0, '0},
      '{16'h7bef, 1'b0, '0},
      '{16'haaaa, 1'b0, '0},
      '{16'h5555, 1'b0, '0},
      '{16'h0020, 1'b0, '0},
      '{16'h0001, 1'b0, '0},
      '{16'h0800, 1'b0, '0},
      '{16'hc618, 1'b0, '0},
      '{16'h4208, 1'b0, '0}
    };
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      push_pixel(dir_rows[i].pixel, dir_rows[i].typed, dir_rows[i].want);
    end
    pix_ch.valid <= 1'b0;
    drain_results();

    for (int ph = 0; ph < PHASES; ph++) begin
      anchor = 16'($urandom);
      ahsl = predict_hsl(anchor, win);
      d = $urandom_range(1, 40);
      case (ph)
        0: w = win;
        2: w = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255};
        3: w = '{8'd240, 8'd0, 8'd240, 8'd0, 8'd240, 8'd0};
        4: begin
          write_reg(REG_SPARE_6, 8'haa);
          write_reg(REG_SPARE_7, 8'h55);
          w = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
        end
        default: begin
          w = '{clip_u8(int'(ahsl.hue) - d), clip_u8(int'(ahsl.hue) + d),
                clip_u8(int'(ahsl.saturation) - d), clip_u8(int'(ahsl.saturation) + d),
                clip_u8(int'(ahsl.luminance) - d), clip_u8(int'(ahsl.luminance) + d)};
        end
      endcase
      if (ph != 0) load_windows(w);
      if (ph == PHASES - 1) quiet = 1'b1;
      repeat (PHASE_ITEMS) push_pixel(pick_pixel(anchor), 1'b0, '0);
      pix_ch.valid <= 1'b0;
      drain_results();
    end

    repeat (2 * PIPE_STAGES) @(posedge clk);
    if (mismatches == 0 && hsl_due.size() == 0) begin
      $display("tb_rgb565_to_hsl_window_match_core passed");
    end else begin
      $display("tb_rgb565_to_hsl_window_match_core failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("tb_rgb565_to_hsl_window_match_core failed");
    $finish;
  end

endmodule
